### rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_HOLDS(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
    else $error(msg);

// Same, on the usual clk / rst_n pair.
`define ASSERT_CLK(label, prop, msg) `ASSERT_HOLDS(label, clk, rst_n, prop, msg)

`endif

### rtl/core/lmrss_pkg.sv
`timescale 1ns / 1ps

package lmrss_pkg;

  // Fixed field widths
  localparam int DATA_W    = 8;
  localparam int ROWS_ON_W = 8;

  // Byte shifted for every pixel slot during init
  localparam logic [DATA_W-1:0] FILL_BYTE = 8'hFF;

  // Result index (within a row) at which the row lines go dark
  localparam int DARK_IDX = 5;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_REFRESH = 2'd1,
    KIND_INIT    = 2'd2
  } kind_t;

  // Result action codes
  localparam logic ACT_SHIFT = 1'b0;
  localparam logic ACT_LATCH = 1'b1;

  // Bank select codes
  localparam logic BANK_ZERO = 1'b0;
  localparam logic BANK_ONE  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_LATCH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_en;
    logic start_refresh;
    logic start_init;
    logic issue_shift;
    logic issue_latch;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic adv;
    logic shift_last;
  } status_t;

endpackage

### rtl/core/led_matrix_row_scan_shifter_top.sv
`timescale 1ns / 1ps

// Row-scan driver for an RGB LED matrix behind a serial column driver.
// Input channel (in_valid / in_stall): kind 0 writes in_byte_value to frame
// byte in_byte_address (24*row + 3*col + channel); kind 1 refreshes the next
// row; kind 2 blanks the rows and fills bank zero with 0xFF. Kind 3 and
// writes past the frame are dropped.
// Result channel (out_valid / out_stall): one item per shifted byte, then a
// latch item with out_last set. Refresh runs columns high to low, blue,
// green, red per pixel, bank select high; rows go dark at the sixth byte and
// the latch lights the refreshed row.
// Sequence: a write is stored when accepted. A refresh or init is accepted,
// then its 3*COLS shift results are issued, latch last, one per cycle while
// the receiver does not stall, from the single frame read port. Each result
// passes stage 1 and the output stage. Only one item is worked on at a time.
// A receiver stall freezes the whole result pipeline and holds out_* steady.
// Reset (synchronous, rst_n low) returns to row 0 with all rows off and
// empties the pipeline; frame contents are kept and need writing before use.

module led_matrix_row_scan_shifter_top #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_kind,
  input  logic [7:0]                      in_byte_address,
  input  logic [lmrss_pkg::DATA_W-1:0]    in_byte_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_action,
  output logic [lmrss_pkg::DATA_W-1:0]    out_data_byte,
  output logic                            out_bank_select,
  output logic [lmrss_pkg::ROWS_ON_W-1:0] out_rows_on,
  output logic                            out_last
);

  lmrss_pkg::cmd_t    cmd;
  lmrss_pkg::status_t status;

  // Sequencer
  lmrss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Frame store, scan counters and result pipeline
  lmrss_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_byte_address (in_byte_address),
    .in_byte_value   (in_byte_value),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_action      (out_action),
    .out_data_byte   (out_data_byte),
    .out_bank_select (out_bank_select),
    .out_rows_on     (out_rows_on),
    .out_last        (out_last)
  );

endmodule

### rtl/core/lmrss_ctrl.sv
`timescale 1ns / 1ps

module lmrss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_stall,
  input  lmrss_pkg::status_t status,
  output lmrss_pkg::cmd_t    cmd
);

  lmrss_pkg::state_t state_r;
  lmrss_pkg::state_t state_nxt;
  lmrss_pkg::kind_t  kind;

  assign kind = lmrss_pkg::kind_t'(in_kind);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmrss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lmrss_pkg::ST_IDLE: begin
        if (in_valid && (kind inside {lmrss_pkg::KIND_REFRESH, lmrss_pkg::KIND_INIT})) begin
          state_nxt = lmrss_pkg::ST_SHIFT;
        end
      end
      lmrss_pkg::ST_SHIFT: begin
        if (status.adv && status.shift_last) begin
          state_nxt = lmrss_pkg::ST_LATCH;
        end
      end
      lmrss_pkg::ST_LATCH: begin
        if (status.adv) begin
          state_nxt = lmrss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lmrss_pkg::ST_IDLE;
    endcase
  end

  // Outputs: take items only when idle, issue one result per free slot
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      lmrss_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (kind)
            lmrss_pkg::KIND_WRITE:   cmd.wr_en         = 1'b1;
            lmrss_pkg::KIND_REFRESH: cmd.start_refresh = 1'b1;
            lmrss_pkg::KIND_INIT:    cmd.start_init    = 1'b1;
            default: ;
          endcase
        end
      end
      lmrss_pkg::ST_SHIFT: cmd.issue_shift = status.adv;
      lmrss_pkg::ST_LATCH: cmd.issue_latch = status.adv;
      default: ;
    endcase
  end

endmodule

### rtl/core/lmrss_datapath.sv
`timescale 1ns / 1ps

module lmrss_datapath #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lmrss_pkg::cmd_t                  cmd,
  output lmrss_pkg::status_t               status,
  input  logic [7:0]                       in_byte_address,
  input  logic [lmrss_pkg::DATA_W-1:0]     in_byte_value,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic                             out_action,
  output logic [lmrss_pkg::DATA_W-1:0]     out_data_byte,
  output logic                             out_bank_select,
  output logic [lmrss_pkg::ROWS_ON_W-1:0]  out_rows_on,
  output logic                             out_last
);

  localparam int ROW_BYTES   = COLS * 3;
  localparam int FRAME_BYTES = ROWS * ROW_BYTES;
  localparam int MEM_AW      = $clog2(FRAME_BYTES);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int K_W         = $clog2(ROW_BYTES);

  // Frame store
  logic [lmrss_pkg::DATA_W-1:0] mem [FRAME_BYTES];
  logic [lmrss_pkg::DATA_W-1:0] mem_q_r;

  // Scan state
  logic [ROW_W-1:0]                  scan_row_r;
  logic [MEM_AW-1:0]                 row_base_r;
  logic [lmrss_pkg::ROWS_ON_W-1:0]   row_mask_r;
  logic                              mode_refresh_r;
  logic [K_W-1:0]                    k_r;
  logic [MEM_AW-1:0]                 ptr_r;

  // Stage 1 (read) and output stage
  logic                              s1_valid_r;
  logic                              s1_action_r;
  logic                              s1_bank_r;
  logic [lmrss_pkg::ROWS_ON_W-1:0]   s1_rows_r;
  logic                              s1_last_r;
  logic                              s1_use_mem_r;
  logic [lmrss_pkg::DATA_W-1:0]      s1_const_r;

  logic                              out_valid_r;
  logic                              out_action_r;
  logic [lmrss_pkg::DATA_W-1:0]      out_data_r;
  logic                              out_bank_r;
  logic [lmrss_pkg::ROWS_ON_W-1:0]   out_rows_r;
  logic                              out_last_r;

  logic                              adv;
  logic                              wr_in_range;
  logic [lmrss_pkg::ROWS_ON_W-1:0]   latch_mask;
  logic [lmrss_pkg::ROWS_ON_W-1:0]   shift_rows;
  logic [lmrss_pkg::ROWS_ON_W-1:0]   latch_rows;

  // Pipeline moves whenever the output slot is empty or being taken
  assign adv = !out_valid_r || !out_stall;

  assign status.adv        = adv;
  assign status.shift_last = (k_r == K_W'(ROW_BYTES - 1));

  assign wr_in_range = (32'(in_byte_address) < FRAME_BYTES);

  // One-hot line for the current row; rows past the mask width have none
  always_comb begin
    for (int i = 0; i < lmrss_pkg::ROWS_ON_W; i++) begin
      latch_mask[i] = (32'(scan_row_r) == 32'(i));
    end
  end

  // Rows go dark from the red byte of the second column on
  assign shift_rows = (k_r >= K_W'(lmrss_pkg::DARK_IDX)) ? '0 : row_mask_r;
  assign latch_rows = mode_refresh_r ? latch_mask : row_mask_r;

  // Frame write
  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_in_range) begin
      mem[MEM_AW'(in_byte_address)] <= in_byte_value;
    end
  end

  // Frame read, registered
  always_ff @(posedge clk) begin
    if (adv && cmd.issue_shift && mode_refresh_r) begin
      mem_q_r <= mem[ptr_r];
    end
  end

  // Row counter, row base and row lines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_row_r     <= '0;
      row_base_r     <= '0;
      row_mask_r     <= '0;
      mode_refresh_r <= 1'b0;
    end else begin
      if (cmd.start_refresh) begin
        mode_refresh_r <= 1'b1;
      end
      if (cmd.start_init) begin
        mode_refresh_r <= 1'b0;
        row_mask_r     <= '0;
      end
      if (cmd.issue_shift && mode_refresh_r && (k_r == K_W'(lmrss_pkg::DARK_IDX))) begin
        row_mask_r <= '0;
      end
      if (cmd.issue_latch && mode_refresh_r) begin
        row_mask_r <= latch_mask;
        if (scan_row_r == ROW_W'(ROWS - 1)) begin
          scan_row_r <= '0;
          row_base_r <= '0;
        end else begin
          scan_row_r <= scan_row_r + 1'b1;
          row_base_r <= row_base_r + MEM_AW'(ROW_BYTES);
        end
      end
    end
  end

  // Byte counter and read pointer: addresses run down from the row's top byte
  always_ff @(posedge clk) begin
    if (cmd.start_refresh || cmd.start_init) begin
      k_r   <= '0;
      ptr_r <= row_base_r + MEM_AW'(ROW_BYTES - 1);
    end else if (cmd.issue_shift) begin
      k_r   <= k_r + 1'b1;
      ptr_r <= ptr_r - 1'b1;
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= cmd.issue_shift || cmd.issue_latch;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_action_r  <= cmd.issue_latch ? lmrss_pkg::ACT_LATCH : lmrss_pkg::ACT_SHIFT;
      s1_bank_r    <= mode_refresh_r ? lmrss_pkg::BANK_ONE : lmrss_pkg::BANK_ZERO;
      s1_rows_r    <= cmd.issue_latch ? latch_rows : shift_rows;
      s1_last_r    <= cmd.issue_latch;
      s1_use_mem_r <= cmd.issue_shift && mode_refresh_r;
      s1_const_r   <= cmd.issue_shift ? lmrss_pkg::FILL_BYTE : '0;
    end
  end

  // Output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Output stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      out_action_r <= s1_action_r;
      out_data_r   <= s1_use_mem_r ? mem_q_r : s1_const_r;
      out_bank_r   <= s1_bank_r;
      out_rows_r   <= s1_rows_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_data_byte   = out_data_r;
  assign out_bank_select = out_bank_r;
  assign out_rows_on     = out_rows_r;
  assign out_last        = out_last_r;

endmodule

### rtl/core/lmrss_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module lmrss_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_action,
  input logic [lmrss_pkg::DATA_W-1:0]    out_data_byte,
  input logic                            out_bank_select,
  input logic [lmrss_pkg::ROWS_ON_W-1:0] out_rows_on,
  input logic                            out_last
);

  // A stalled result item holds
  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable(out_action) &&
      $stable(out_data_byte) && $stable(out_bank_select) &&
      $stable(out_rows_on) && $stable(out_last);
  endproperty

  // Latch and last mark go together
  property p_latch_last;
    out_valid |-> ((out_action == lmrss_pkg::ACT_LATCH) == out_last);
  endproperty

  // A latch lights at most one row
  property p_latch_onehot;
    out_valid && (out_action == lmrss_pkg::ACT_LATCH) |-> $onehot0(out_rows_on);
  endproperty

  // Bank zero init keeps every row dark
  property p_init_dark;
    out_valid && (out_bank_select == lmrss_pkg::BANK_ZERO) |-> (out_rows_on == '0);
  endproperty

  // Latch items carry a zero data byte
  property p_latch_zero;
    out_valid && (out_action == lmrss_pkg::ACT_LATCH) |-> (out_data_byte == '0);
  endproperty

  `ASSERT_CLK(a_out_hold, p_out_hold, "stalled result item changed")
  `ASSERT_CLK(a_latch_last, p_latch_last, "last mark not on latch item")
  `ASSERT_CLK(a_latch_onehot, p_latch_onehot, "latch lit more than one row")
  `ASSERT_CLK(a_init_dark, p_init_dark, "rows lit during bank zero init")
  `ASSERT_CLK(a_latch_zero, p_latch_zero, "latch item with nonzero data")

endmodule

bind led_matrix_row_scan_shifter_top lmrss_checker u_lmrss_checker (.*);
